### rtl/vac_pkg.sv
`default_nettype none

package vac_pkg;

    // request kinds
    localparam logic [1:0] KIND_PLAY   = 2'd0;
    localparam logic [1:0] KIND_STOP   = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;
    localparam logic [1:0] KIND_FINISH = 2'd3;

    // voice list operations
    localparam logic [1:0] LOP_NONE   = 2'd0;
    localparam logic [1:0] LOP_ROT    = 2'd1;
    localparam logic [1:0] LOP_DROP   = 2'd2;
    localparam logic [1:0] LOP_APPEND = 2'd3;

    localparam logic [4:0] LIMIT_RESET = 5'd16;

    typedef struct packed {
        logic [1:0] op;
        logic       clr_play;
    } t_list_ctl;

    typedef struct packed {
        logic set_en;
        logic start;
        logic step;
        logic take;
    } t_map_ctl;

endpackage

`default_nettype wire

### rtl/vac_list.sv
`default_nettype none

module vac_list #(
    parameter int POOL_DEPTH = 16,
    parameter int ID_BITS = 32,
    localparam int SW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1,
    localparam int CW = $clog2(POOL_DEPTH + 1)
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire vac_pkg::t_list_ctl  i_ctl,
    input  wire logic [SW-1:0]       i_app_slot,
    input  wire logic [ID_BITS-1:0]  i_app_id,
    output logic [SW-1:0]            o_head_slot,
    output logic [ID_BITS-1:0]       o_head_id,
    output logic                     o_head_play,
    output logic [CW-1:0]            o_cnt
);
    import vac_pkg::*;

    logic [SW-1:0]      r_slot [POOL_DEPTH];
    logic [ID_BITS-1:0] r_id   [POOL_DEPTH];
    logic               r_play [POOL_DEPTH];
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      cnt_m1;

    assign cnt_m1 = r_cnt - 1'b1;

    // position 0 is the oldest entry; rotation sends the head to the back of the live region
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int k = 0; k < POOL_DEPTH; k++) begin
                r_play[k] <= 1'b0;
            end
        end else begin
            unique case (i_ctl.op)
                LOP_ROT: begin
                    for (int k = 0; k < POOL_DEPTH; k++) begin
                        if (CW'(k) == cnt_m1) begin
                            r_play[k] <= r_play[0] & ~i_ctl.clr_play;
                        end else if (CW'(k) < cnt_m1) begin
                            r_play[k] <= r_play[(k + 1 < POOL_DEPTH) ? k + 1 : k];
                        end
                    end
                end
                LOP_DROP: begin
                    for (int k = 0; k < POOL_DEPTH - 1; k++) begin
                        r_play[k] <= r_play[k + 1];
                    end
                    r_cnt <= cnt_m1;
                end
                LOP_APPEND: begin
                    for (int k = 0; k < POOL_DEPTH; k++) begin
                        if (CW'(k) == r_cnt) begin
                            r_play[k] <= 1'b1;
                        end
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_ctl.op)
            LOP_ROT: begin
                for (int k = 0; k < POOL_DEPTH; k++) begin
                    if (CW'(k) == cnt_m1) begin
                        r_slot[k] <= r_slot[0];
                        r_id[k]   <= r_id[0];
                    end else if (CW'(k) < cnt_m1) begin
                        r_slot[k] <= r_slot[(k + 1 < POOL_DEPTH) ? k + 1 : k];
                        r_id[k]   <= r_id[(k + 1 < POOL_DEPTH) ? k + 1 : k];
                    end
                end
            end
            LOP_DROP: begin
                for (int k = 0; k < POOL_DEPTH - 1; k++) begin
                    r_slot[k] <= r_slot[k + 1];
                    r_id[k]   <= r_id[k + 1];
                end
            end
            LOP_APPEND: begin
                for (int k = 0; k < POOL_DEPTH; k++) begin
                    if (CW'(k) == r_cnt) begin
                        r_slot[k] <= i_app_slot;
                        r_id[k]   <= i_app_id;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_head_slot = r_slot[0];
    assign o_head_id   = r_id[0];
    assign o_head_play = r_play[0];
    assign o_cnt       = r_cnt;

endmodule

`default_nettype wire

### rtl/vac_free_map.sv
`default_nettype none

module vac_free_map #(
    parameter int POOL_DEPTH = 16,
    localparam int SW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire vac_pkg::t_map_ctl  i_ctl,
    input  wire logic [SW-1:0]      i_set_slot,
    output logic [POOL_DEPTH-1:0]   o_free_map,
    output logic                    o_hit,
    output logic [SW-1:0]           o_idx
);
    import vac_pkg::*;

    logic [POOL_DEPTH-1:0] r_map;
    logic [POOL_DEPTH-1:0] r_scan;
    logic [SW-1:0]         r_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '1;
        end else begin
            if (i_ctl.set_en) begin
                r_map[i_set_slot] <= 1'b1;
            end
            if (i_ctl.take) begin
                r_map[r_idx] <= 1'b0;
            end
        end
    end

    // lowest free slot found one bit a cycle, while step is high, from a shifted copy
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_scan <= r_map;
            r_idx  <= '0;
        end else if (i_ctl.step) begin
            r_scan <= r_scan >> 1;
            r_idx  <= r_idx + 1'b1;
        end
    end

    assign o_free_map = r_map;
    assign o_hit      = r_scan[0];
    assign o_idx      = r_idx;

endmodule

`default_nettype wire

### rtl/voice_allocator_with_stealing_core.sv
`default_nettype none

// steps: trim the list to the limit (d entries dropped), visit each of the n live entries,
//   then finish; a play that reuses or steals a voice appends first, and a play that takes a
//   fresh slot scans the free map before it appends; one comparator visits one list entry per cycle
// one item at a time: a new item is taken only when the block is idle again
// a finished result waits in the output register while the next item is taken
// reset: synchronous active low; clears the list and id counter, frees every slot, limit 16
module voice_allocator_with_stealing_core #(
    parameter int POOL_DEPTH = 16,
    parameter int ID_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [1:0]         i_kind,
    input  wire logic [31:0]        i_target_id,
    input  wire logic [3:0]         i_finished_slot,
    input  wire logic [15:0]        i_clip_handle,
    input  wire logic [15:0]        i_gain_in,
    input  wire logic signed [15:0] i_pos_x_in,
    input  wire logic signed [15:0] i_pos_y_in,
    input  wire logic signed [15:0] i_pos_z_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output logic [31:0]             o_result_id,
    output logic [3:0]              o_voice_slot,
    output logic                    o_start_voice,
    output logic                    o_stop_voice,
    output logic                    o_id_found,
    output logic                    o_is_playing_out,
    output logic [15:0]             o_clip_out,
    output logic [15:0]             o_gain_out,
    output logic signed [15:0]      o_pos_x_out,
    output logic signed [15:0]      o_pos_y_out,
    output logic signed [15:0]      o_pos_z_out,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [4:0]         i_cfg_voice_limit
);
    import vac_pkg::*;

    localparam int SW   = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
    localparam int CW   = $clog2(POOL_DEPTH + 1);
    localparam int IXW  = (ID_BITS > 32) ? ID_BITS : 32;
    localparam int CMPW = (SW > 4) ? SW : 4;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_TRIM   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_POST   = 3'd3;
    localparam logic [2:0] S_FREE   = 3'd4;
    localparam logic [2:0] S_APPEND = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [4:0]         r_limit;
    logic [ID_BITS-1:0] r_last, n_last;
    logic               r_pend, n_pend;
    logic [CW-1:0]      r_left, n_left;
    logic               r_found, n_found;
    logic [SW-1:0]      r_sel_slot, n_sel_slot;
    logic               r_sel_play, n_sel_play;

    logic [1:0]         r_kind;
    logic [31:0]        r_target;
    logic [3:0]         r_fin;
    logic [15:0]        r_clip, r_gain;
    logic signed [15:0] r_px, r_py, r_pz;

    logic               r_out_valid;
    logic [31:0]        r_o_id;
    logic [3:0]         r_o_slot;
    logic               r_o_start, r_o_stop, r_o_found, r_o_play;
    logic [15:0]        r_o_clip, r_o_gain;
    logic signed [15:0] r_o_px, r_o_py, r_o_pz;

    t_list_ctl             list_ctl;
    t_map_ctl              map_ctl;
    logic [SW-1:0]         head_slot;
    logic [ID_BITS-1:0]    head_id;
    logic                  head_play;
    logic [CW-1:0]         list_cnt;
    logic [POOL_DEPTH-1:0] free_map;
    logic                  map_hit;
    logic [SW-1:0]         map_idx;

    logic [CW-1:0]  lim;
    logic           hit, match;
    logic           in_acc, cfg_acc, out_load;
    logic [IXW-1:0] last_ext;
    logic [CMPW-1:0] sel_ext;

    vac_list #(
        .POOL_DEPTH (POOL_DEPTH),
        .ID_BITS    (ID_BITS)
    ) u_list (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (list_ctl),
        .i_app_slot  (r_sel_slot),
        .i_app_id    (r_last),
        .o_head_slot (head_slot),
        .o_head_id   (head_id),
        .o_head_play (head_play),
        .o_cnt       (list_cnt)
    );

    vac_free_map #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_map (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (map_ctl),
        .i_set_slot (head_slot),
        .o_free_map (free_map),
        .o_hit      (map_hit),
        .o_idx      (map_idx)
    );

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_in_stall  = (r_state != S_IDLE) || i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);

    // limit zero acts as one, above the pool as the pool
    always_comb begin
        if (r_limit == '0) begin
            lim = CW'(1);
        end else if (int'(r_limit) > POOL_DEPTH) begin
            lim = CW'(POOL_DEPTH);
        end else begin
            lim = CW'(r_limit);
        end
    end

    // the shared compare unit, always looking at the head of the list
    always_comb begin
        unique case (r_kind)
            KIND_PLAY:               hit = !head_play;
            KIND_STOP, KIND_QUERY:   hit = (r_target != '0) &&
                                           (IXW'(head_id) == IXW'(r_target));
            KIND_FINISH:             hit = (CMPW'(head_slot) == CMPW'(r_fin));
            default:                 hit = 1'b0;
        endcase
        match = !r_found && hit;
    end

    always_comb begin
        n_last = r_last + 1'b1;
        if (n_last == '0) begin
            n_last = ID_BITS'(1);
        end
    end

    always_comb begin
        n_state    = r_state;
        n_pend     = r_pend;
        n_left     = r_left;
        n_found    = r_found;
        n_sel_slot = r_sel_slot;
        n_sel_play = r_sel_play;
        list_ctl   = '{op: LOP_NONE, clr_play: 1'b0};
        map_ctl    = '0;
        unique case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_state = S_TRIM;
                    n_pend  = 1'b0;
                end else if (in_acc) begin
                    n_state = S_TRIM;
                    n_pend  = 1'b1;
                end
            end
            S_TRIM: begin
                if (list_cnt > lim) begin
                    list_ctl.op    = LOP_DROP;
                    map_ctl.set_en = 1'b1;
                end else if (r_pend) begin
                    n_left  = list_cnt;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (r_left == '0) begin
                    n_state = S_POST;
                end else begin
                    n_left = r_left - 1'b1;
                    if (match && r_kind == KIND_PLAY) begin
                        list_ctl.op = LOP_DROP;
                    end else begin
                        list_ctl.op       = LOP_ROT;
                        list_ctl.clr_play = match &&
                                            (r_kind == KIND_STOP || r_kind == KIND_FINISH);
                    end
                    if (match) begin
                        n_found    = 1'b1;
                        n_sel_slot = head_slot;
                        n_sel_play = head_play;
                    end
                end
            end
            S_POST: begin
                if (r_kind != KIND_PLAY) begin
                    n_state = S_DONE;
                end else if (r_found) begin
                    n_state = S_APPEND;
                end else if (list_cnt >= lim && list_cnt != '0) begin
                    // steal the oldest voice
                    list_ctl.op = LOP_DROP;
                    n_sel_slot  = head_slot;
                    n_state     = S_APPEND;
                end else begin
                    map_ctl.start = 1'b1;
                    n_state       = S_FREE;
                end
            end
            S_FREE: begin
                if (map_hit) begin
                    map_ctl.take = 1'b1;
                    n_sel_slot   = map_idx;
                    n_state      = S_APPEND;
                end else begin
                    map_ctl.step = 1'b1;
                end
            end
            S_APPEND: begin
                list_ctl.op = LOP_APPEND;
                n_state     = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_last      <= '0;
            r_pend      <= 1'b0;
            r_left      <= '0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_left  <= n_left;
            r_found <= n_found;
            if (cfg_acc) begin
                r_limit <= i_cfg_voice_limit;
            end
            if (in_acc && i_kind == KIND_PLAY) begin
                r_last <= n_last;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel_slot <= n_sel_slot;
        r_sel_play <= n_sel_play;
        if (in_acc) begin
            r_kind   <= i_kind;
            r_target <= i_target_id;
            r_fin    <= i_finished_slot;
            r_clip   <= i_clip_handle;
            r_gain   <= i_gain_in;
            r_px     <= i_pos_x_in;
            r_py     <= i_pos_y_in;
            r_pz     <= i_pos_z_in;
        end
    end

    assign last_ext = IXW'(r_last);
    assign sel_ext  = CMPW'(r_sel_slot);

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_id    <= (r_kind == KIND_PLAY) ? last_ext[31:0] : '0;
            r_o_slot  <= ((r_kind == KIND_PLAY) || (r_kind == KIND_STOP && r_found)) ?
                         sel_ext[3:0] : '0;
            r_o_start <= (r_kind == KIND_PLAY);
            r_o_stop  <= (r_kind == KIND_STOP) && r_found;
            r_o_found <= (r_kind == KIND_STOP || r_kind == KIND_QUERY) && r_found;
            r_o_play  <= (r_kind == KIND_QUERY) && r_found && r_sel_play;
            r_o_clip  <= (r_kind == KIND_PLAY) ? r_clip : '0;
            r_o_gain  <= (r_kind == KIND_PLAY) ? r_gain : '0;
            r_o_px    <= (r_kind == KIND_PLAY) ? r_px : '0;
            r_o_py    <= (r_kind == KIND_PLAY) ? r_py : '0;
            r_o_pz    <= (r_kind == KIND_PLAY) ? r_pz : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_id      = r_o_id;
    assign o_voice_slot     = r_o_slot;
    assign o_start_voice    = r_o_start;
    assign o_stop_voice     = r_o_stop;
    assign o_id_found       = r_o_found;
    assign o_is_playing_out = r_o_play;
    assign o_clip_out       = r_o_clip;
    assign o_gain_out       = r_o_gain;
    assign o_pos_x_out      = r_o_px;
    assign o_pos_y_out      = r_o_py;
    assign o_pos_z_out      = r_o_pz;

    // between items the list never holds more than the limit allows
    a_cnt_within_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (list_cnt <= lim))
        else $error("voice list longer than the limit while idle");

    // every slot is either in the list or in the free map: free count plus list length is the pool depth
    a_slot_conservation: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ($countones(free_map) + int'(list_cnt) == POOL_DEPTH))
        else $error("free map and voice list disagree on slot count");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result beat not presented after completion");

endmodule

`default_nettype wire

### test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vac_pkg::*;

    localparam int SLOTS = 16;

    typedef struct packed {
        logic [1:0]         kind;
        logic [31:0]        target_id;
        logic [3:0]         finished_slot;
        logic [15:0]        clip;
        logic [15:0]        gain;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_voice_req;

    typedef struct packed {
        logic [31:0]        result_id;
        logic [3:0]         voice_slot;
        logic               start_voice;
        logic               stop_voice;
        logic               id_found;
        logic               still_on;
        logic [15:0]        clip;
        logic [15:0]        gain;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] pos_z;
    } t_voice_cmd;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         kind = KIND_PLAY;
    logic [31:0]        target_id = '0;
    logic [3:0]         finished_slot = '0;
    logic [15:0]        clip_handle = '0;
    logic [15:0]        gain_in = '0;
    logic signed [15:0] pos_x_in = '0;
    logic signed [15:0] pos_y_in = '0;
    logic signed [15:0] pos_z_in = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [31:0]        result_id;
    logic [3:0]         voice_slot;
    logic               start_voice;
    logic               stop_voice;
    logic               id_found;
    logic               is_playing_out;
    logic [15:0]        clip_out;
    logic [15:0]        gain_out;
    logic signed [15:0] pos_x_out;
    logic signed [15:0] pos_y_out;
    logic signed [15:0] pos_z_out;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [4:0]         cfg_limit = LIMIT_RESET;

    // voice list as the block should hold it, oldest at index 0
    logic [3:0]       pool_slot [SLOTS];
    logic [31:0]      pool_id [SLOTS];
    logic             pool_playing [SLOTS];
    int               pool_live;
    logic [31:0]      id_counter;
    logic [SLOTS-1:0] free_slots;
    logic [4:0]       limit_reg;

    t_voice_cmd cmd_queue [$];
    int         fail_count = 0;
    int         gap_odds = 0;
    int         stall_odds = 0;
    int         stall_left = 0;
    logic       result_beat = 1'b0;
    t_voice_cmd result_seen;

    voice_allocator_with_stealing_core dut (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_kind            (kind),
        .i_target_id       (target_id),
        .i_finished_slot   (finished_slot),
        .i_clip_handle     (clip_handle),
        .i_gain_in         (gain_in),
        .i_pos_x_in        (pos_x_in),
        .i_pos_y_in        (pos_y_in),
        .i_pos_z_in        (pos_z_in),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_result_id       (result_id),
        .o_voice_slot      (voice_slot),
        .o_start_voice     (start_voice),
        .o_stop_voice      (stop_voice),
        .o_id_found        (id_found),
        .o_is_playing_out  (is_playing_out),
        .o_clip_out        (clip_out),
        .o_gain_out        (gain_out),
        .o_pos_x_out       (pos_x_out),
        .o_pos_y_out       (pos_y_out),
        .o_pos_z_out       (pos_z_out),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_voice_limit (cfg_limit)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic int live_cap();
        if (limit_reg == 5'd0) return 1;
        if (limit_reg > SLOTS) return SLOTS;
        return int'(limit_reg);
    endfunction

    function automatic void pool_remove(int idx);
        for (int k = idx; k + 1 < pool_live; k++) begin
            pool_slot[k] = pool_slot[k + 1];
            pool_id[k] = pool_id[k + 1];
            pool_playing[k] = pool_playing[k + 1];
        end
        pool_live--;
        pool_playing[pool_live] = 1'b0;
    endfunction

    function automatic void pool_trim();
        while (pool_live > live_cap()) begin
            free_slots[pool_slot[0]] = 1'b1;
            pool_remove(0);
        end
    endfunction

    function automatic int find_voice(logic [31:0] id);
        if (id == 32'd0) return -1;
        for (int i = 0; i < pool_live; i++)
            if (pool_id[i] == id) return i;
        return -1;
    endfunction

    function automatic t_voice_cmd predict_voice_cmd(t_voice_req rq);
        t_voice_cmd c;
        int         hit;
        logic [3:0] pick;
        logic       got;
        c = '0;
        pick = '0;
        got = 1'b0;
        pool_trim();
        case (rq.kind)
            KIND_PLAY: begin
                id_counter = id_counter + 32'd1;
                if (id_counter == 32'd0) id_counter = 32'd1;
                // oldest idle voice first, then steal the oldest, then a fresh slot
                for (int i = 0; i < pool_live; i++) begin
                    if (!pool_playing[i]) begin
                        pick = pool_slot[i];
                        pool_remove(i);
                        got = 1'b1;
                        break;
                    end
                end
                if (!got && pool_live >= live_cap() && pool_live > 0) begin
                    pick = pool_slot[0];
                    pool_remove(0);
                    got = 1'b1;
                end
                if (!got) begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (free_slots[i]) begin
                            pick = 4'(i);
                            free_slots[i] = 1'b0;
                            got = 1'b1;
                            break;
                        end
                    end
                end
                if (got && pool_live < SLOTS) begin
                    pool_slot[pool_live] = pick;
                    pool_id[pool_live] = id_counter;
                    pool_playing[pool_live] = 1'b1;
                    pool_live++;
                end
                c.result_id = id_counter;
                c.voice_slot = pick;
                c.start_voice = 1'b1;
                c.clip = rq.clip;
                c.gain = rq.gain;
                c.pos_x = rq.pos_x;
                c.pos_y = rq.pos_y;
                c.pos_z = rq.pos_z;
            end
            KIND_STOP: begin
                hit = find_voice(rq.target_id);
                if (hit >= 0) begin
                    pool_playing[hit] = 1'b0;
                    c.voice_slot = pool_slot[hit];
                    c.stop_voice = 1'b1;
                    c.id_found = 1'b1;
                end
            end
            KIND_QUERY: begin
                hit = find_voice(rq.target_id);
                if (hit >= 0) begin
                    c.id_found = 1'b1;
                    c.still_on = pool_playing[hit];
                end
            end
            default: begin
                for (int i = 0; i < pool_live; i++) begin
                    if (pool_slot[i] == rq.finished_slot) begin
                        pool_playing[i] = 1'b0;
                        break;
                    end
                end
            end
        endcase
        return c;
    endfunction

    function automatic t_voice_req make_req(input logic [1:0] k, input logic [31:0] tid,
                                            input logic [3:0] fs, input logic [15:0] clip,
                                            input logic [15:0] gain,
                                            input logic signed [15:0] x,
                                            input logic signed [15:0] y,
                                            input logic signed [15:0] z);
        t_voice_req rq;
        rq.kind = k;
        rq.target_id = tid;
        rq.finished_slot = fs;
        rq.clip = clip;
        rq.gain = gain;
        rq.pos_x = x;
        rq.pos_y = y;
        rq.pos_z = z;
        return rq;
    endfunction

    // mostly live ids and slots so stops, queries and finishes land on real voices
    function automatic t_voice_req random_request(int play_pct);
        t_voice_req rq;
        int         roll;
        roll = $urandom_range(99, 0);
        if (roll < play_pct)
            rq.kind = KIND_PLAY;
        else if (roll < play_pct + (100 - play_pct) / 3)
            rq.kind = KIND_STOP;
        else if (roll < play_pct + 2 * (100 - play_pct) / 3)
            rq.kind = KIND_QUERY;
        else
            rq.kind = KIND_FINISH;
        roll = $urandom_range(9, 0);
        if (roll == 0)
            rq.target_id = 32'd0;
        else if (roll == 1 || pool_live == 0)
            rq.target_id = $urandom;
        else if (roll == 2)
            rq.target_id = id_counter - 32'($urandom_range(20, 0));
        else
            rq.target_id = pool_id[$urandom_range(pool_live - 1, 0)];
        if (pool_live > 0 && $urandom_range(9, 0) < 7)
            rq.finished_slot = pool_slot[$urandom_range(pool_live - 1, 0)];
        else
            rq.finished_slot = 4'($urandom_range(15, 0));
        rq.clip = 16'($urandom);
        rq.gain = 16'($urandom);
        rq.pos_x = 16'($urandom);
        rq.pos_y = 16'($urandom);
        rq.pos_z = 16'($urandom);
        return rq;
    endfunction

    task automatic flag_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        if (fail_count < 100)
            $display("%0t  mismatch %s: got %h want %h", $realtime, what, got, want);
        fail_count++;
    endtask

    task automatic match_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) flag_error(name, got, want);
    endtask

    // called at a rising edge; returns at the edge where the beat is taken
    task automatic send_request(input t_voice_req rq);
        int   gap;
        logic took;
        gap = 0;
        if (gap_odds > 0 && $urandom_range(99, 0) < gap_odds) gap = $urandom_range(17, 1);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= rq.kind;
        target_id <= rq.target_id;
        finished_slot <= rq.finished_slot;
        clip_handle <= rq.clip;
        gain_in <= rq.gain;
        pos_x_in <= rq.pos_x;
        pos_y_in <= rq.pos_y;
        pos_z_in <= rq.pos_z;
        do begin
            @(negedge clk);
            took = !in_stall;
            @(posedge clk);
        end while (!took);
        cmd_queue.push_back(predict_voice_cmd(rq));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        wait (cmd_queue.size() == 0);
        @(posedge clk);
    endtask

    task automatic write_limit(input logic [4:0] value);
        logic took;
        settle();
        cfg_valid <= 1'b1;
        cfg_limit <= value;
        do begin
            @(negedge clk);
            took = cfg_ready;
            @(posedge clk);
        end while (!took);
        cfg_valid <= 1'b0;
        limit_reg = value;
        pool_trim();
    endtask

    task automatic send_play();
        send_request(make_req(KIND_PLAY, '0, '0, 16'($urandom), 16'($urandom),
                              16'($urandom), 16'($urandom), 16'($urandom)));
    endtask

    // output side stall bursts
    always @(posedge clk) begin
        if (stall_left == 0 && stall_odds > 0 && $urandom_range(99, 0) < stall_odds)
            stall_left = $urandom_range(17, 1);
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // sample away from the active edge so nothing races the block's registers
    always @(negedge clk) begin
        result_beat = rst_n && out_valid && !out_stall;
        result_seen.result_id = result_id;
        result_seen.voice_slot = voice_slot;
        result_seen.start_voice = start_voice;
        result_seen.stop_voice = stop_voice;
        result_seen.id_found = id_found;
        result_seen.still_on = is_playing_out;
        result_seen.clip = clip_out;
        result_seen.gain = gain_out;
        result_seen.pos_x = pos_x_out;
        result_seen.pos_y = pos_y_out;
        result_seen.pos_z = pos_z_out;
    end

    always @(posedge clk) begin
        t_voice_cmd want;
        if (result_beat) begin
            if (cmd_queue.size() == 0) begin
                flag_error("unexpected result beat", result_seen.result_id, '0);
            end else begin
                want = cmd_queue[0];
                cmd_queue.delete(0);
                match_field("result_id", result_seen.result_id, want.result_id);
                match_field("voice_slot", result_seen.voice_slot, want.voice_slot);
                match_field("start_voice", result_seen.start_voice, want.start_voice);
                match_field("stop_voice", result_seen.stop_voice, want.stop_voice);
                match_field("id_found", result_seen.id_found, want.id_found);
                match_field("is_playing_out", result_seen.still_on, want.still_on);
                match_field("clip_out", result_seen.clip, want.clip);
                match_field("gain_out", result_seen.gain, want.gain);
                match_field("pos_x_out", result_seen.pos_x, want.pos_x);
                match_field("pos_y_out", result_seen.pos_y, want.pos_y);
                match_field("pos_z_out", result_seen.pos_z, want.pos_z);
            end
        end
    end

    task automatic test_directed_cases();
        gap_odds = 10;
        stall_odds = 10;
        // ids start at 1 after reset
        send_request(make_req(KIND_PLAY, '0, '0, 16'h0000, 16'h0000,
                              -16'sd32768, -16'sd32768, -16'sd32768));
        send_request(make_req(KIND_PLAY, 32'hFFFF_FFFF, 4'hF, 16'hFFFF, 16'hFFFF,
                              16'sd32767, 16'sd32767, 16'sd32767));
        send_request(make_req(KIND_PLAY, '0, '0, 16'h5A5A, 16'h1000, 16'sd0, 16'sd1, -16'sd1));
        send_request(make_req(KIND_QUERY, 32'd2, '0, '0, '0, '0, '0, '0));
        // null id never matches
        send_request(make_req(KIND_QUERY, 32'd0, '0, '0, '0, '0, '0, '0));
        send_request(make_req(KIND_STOP, 32'd0, '0, '0, '0, '0, '0, '0));
        send_request(make_req(KIND_QUERY, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0));
        send_request(make_req(KIND_STOP, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0));
        send_request(make_req(KIND_FINISH, 32'hFFFF_FFFF, 4'd1, 16'hFFFF, 16'hFFFF,
                              -16'sd1, -16'sd1, -16'sd1));
        send_request(make_req(KIND_QUERY, 32'd2, '0, '0, '0, '0, '0, '0));
        // finished slot that holds no voice
        send_request(make_req(KIND_FINISH, '0, 4'd15, '0, '0, '0, '0, '0));
        send_request(make_req(KIND_STOP, 32'd1, '0, '0, '0, '0, '0, '0));
        // stopping an idle voice still gives a stop command
        send_request(make_req(KIND_STOP, 32'd1, '0, '0, '0, '0, '0, '0));
        send_play();
        send_play();
        send_request(make_req(KIND_QUERY, 32'd1, '0, '0, '0, '0, '0, '0));
        send_request(make_req(KIND_STOP, 32'd3, '0, '0, '0, '0, '0, '0));
        send_request(make_req(KIND_FINISH, '0, 4'd2, '0, '0, '0, '0, '0));
        send_play();
    endtask

    task automatic test_limit_changes();
        // lowering the limit drops the oldest voices silently
        write_limit(5'd1);
        send_play();
        send_play();
        send_request(make_req(KIND_FINISH, '0, pool_slot[0], '0, '0, '0, '0, '0));
        send_play();
        write_limit(5'd0);
        send_play();
        write_limit(5'd31);
        send_play();
        send_play();
        send_play();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: write_limit(5'd16);
                1: write_limit(5'd1);
                2: write_limit(5'($urandom_range(15, 2)));
                3: write_limit(5'd0);
                default: write_limit(5'd31);
            endcase
            gap_odds = (ph % 3 == 0) ? 0 : (ph % 3 == 1) ? 6 : 25;
            stall_odds = (ph % 3 == 2) ? 0 : (ph % 3 == 1) ? 20 : 6;
            for (int n = 0; n < 200; n++)
                send_request(random_request(ph == 0 ? 70 : 40));
        end
    endtask

    task automatic test_steady_stream();
        write_limit(5'($urandom_range(16, 1)));
        gap_odds = 0;
        stall_odds = 0;
        for (int n = 0; n < 130; n++)
            send_request(random_request(45));
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            pool_slot[i] = '0;
            pool_id[i] = '0;
            pool_playing[i] = 1'b0;
        end
        pool_live = 0;
        id_counter = '0;
        free_slots = '1;
        limit_reg = LIMIT_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_limit_changes();
        test_random_traffic();
        test_steady_stream();
        settle();
        repeat (60) @(posedge clk);
        if (fail_count == 0 && cmd_queue.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #8ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
